/* sv/lfu_cache_replacement_unit_assert.svh */
// Assertion macros for the LFU replacement unit.
`ifndef LFU_CACHE_REPLACEMENT_UNIT_ASSERT_SVH
`define LFU_CACHE_REPLACEMENT_UNIT_ASSERT_SVH

// Check an effect in the same cycle as its cause.
`define LFU_ASSERT_NOW(name, clock, reset, cause, effect) \
  name: assert property (@(posedge clock) disable iff (reset) (cause) |-> (effect)) \
    else $error("lfu replacement unit: same-cycle check failed");

// Check an effect in the cycle after its cause.
`define LFU_ASSERT_NEXT(name, clock, reset, cause, effect) \
  name: assert property (@(posedge clock) disable iff (reset) (cause) |=> (effect)) \
    else $error("lfu replacement unit: next-cycle check failed");

`endif

/* sv/lfu_pkg.sv */
package lfu_pkg;

  localparam int KEY_W      = 32;
  localparam int CAP_W      = 7;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

  // Word index of the capacity register (paddr bit 2).
  localparam logic REG_CAPACITY = 1'b0;

  // Per-row control towards the shared row unit.
  typedef struct packed {
    logic clear;
    logic scan;
    logic update;
    logic row_valid;
  } row_ctl_t;

  // Outcome of the lookup pass.
  typedef struct packed {
    logic found;
    logic have_victim;
    logic have_free;
  } scan_res_t;

endpackage

/* sv/lfu_ram.sv */
module lfu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/lfu_row_unit.sv */
module lfu_row_unit #(
  parameter int IDX_W      = 6,
  parameter int COUNT_BITS = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  lfu_pkg::row_ctl_t        ctl,
  input  logic [IDX_W-1:0]         idx,
  input  logic [lfu_pkg::KEY_W-1:0] row_key,
  input  logic [COUNT_BITS-1:0]    row_count,
  input  logic [IDX_W-1:0]         row_rank,
  input  logic [lfu_pkg::KEY_W-1:0] req_key,
  input  logic [IDX_W-1:0]         target,
  input  logic [IDX_W-1:0]         limit,
  input  logic                     age_all,
  input  logic [lfu_pkg::KEY_W-1:0] tgt_key,
  input  logic [COUNT_BITS-1:0]    tgt_count,
  output lfu_pkg::scan_res_t       sres,
  output logic [IDX_W-1:0]         hit_slot,
  output logic [IDX_W-1:0]         hit_rank,
  output logic [COUNT_BITS-1:0]    hit_count,
  output logic [IDX_W-1:0]         vic_slot,
  output logic [lfu_pkg::KEY_W-1:0] vic_key,
  output logic [COUNT_BITS-1:0]    vic_count,
  output logic [IDX_W-1:0]         vic_rank,
  output logic [IDX_W-1:0]         free_slot,
  output logic                     upd_en,
  output logic [lfu_pkg::KEY_W-1:0] upd_key,
  output logic [COUNT_BITS-1:0]    upd_count,
  output logic [IDX_W-1:0]         upd_rank
);

  import lfu_pkg::*;

  logic key_match;
  logic take_victim;
  logic is_target;
  logic ages;

  always_comb begin
    key_match   = ctl.row_valid && (row_key == req_key);
    // Lower count wins; on equal counts the older entry (higher rank) wins.
    take_victim = ctl.row_valid &&
                  (!sres.have_victim || (row_count < vic_count) ||
                   ((row_count == vic_count) && (row_rank > vic_rank)));
    is_target   = (idx == target);
    ages        = ctl.row_valid && (age_all || (row_rank < limit));
    upd_en      = ctl.update && (is_target || ages);
    upd_key     = is_target ? tgt_key : row_key;
    upd_count   = is_target ? tgt_count : row_count;
    upd_rank    = is_target ? '0 : row_rank + IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      sres <= '0;
    end else if (ctl.scan) begin
      if (key_match && !sres.found) begin
        sres.found <= 1'b1;
      end
      if (take_victim) begin
        sres.have_victim <= 1'b1;
      end
      if (!ctl.row_valid && !sres.have_free) begin
        sres.have_free <= 1'b1;
      end
    end
  end

  // Hold the candidates found so far.
  always_ff @(posedge clk) begin
    if (ctl.scan) begin
      if (key_match && !sres.found) begin
        hit_slot  <= idx;
        hit_rank  <= row_rank;
        hit_count <= row_count;
      end
      if (take_victim) begin
        vic_slot  <= idx;
        vic_key   <= row_key;
        vic_count <= row_count;
        vic_rank  <= row_rank;
      end
      if (!ctl.row_valid && !sres.have_free) begin
        free_slot <= idx;
      end
    end
  end

endmodule

/* sv/lfu_cache_replacement_unit.sv */
// LFU replacement unit with LRU tie-break, fully associative, ENTRIES slots.
// Request channel: req_valid/req_ready carry req_key. Result channel:
// res_valid/res_ready carry hit, evicted and evicted_key (zero unless a
// resident entry was removed). One result per request, in order.
// Capacity register at APB word 0 (7 bits, reset 64); write it only while
// the unit is idle. A capacity of zero answers every request as a miss
// and leaves the table alone. Otherwise a request makes one pass over the
// entry RAM to find a hit, the victim and a free slot, takes a decision
// step, makes a second pass over the RAM that ages the recency ranks and
// writes the chosen row, then loads the result. The entry RAM is read one
// row per cycle; one request is in the unit at a time, and req_ready is
// high only when it is idle, also while an earlier result still waits.
// If the receiver stalls, the finished result holds the unit in its last
// step until the output register is free. Reset clears all valid bits,
// the resident count and both channels; RAM contents stay undefined.
`include "lfu_cache_replacement_unit_assert.svh"

module lfu_cache_replacement_unit #(
  parameter int ENTRIES    = 64,
  parameter int COUNT_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [lfu_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [lfu_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [lfu_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                pready,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic signed [lfu_pkg::KEY_W-1:0]    req_key,
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic                                hit,
  output logic                                evicted,
  output logic signed [lfu_pkg::KEY_W-1:0]    evicted_key
);

  import lfu_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int ROW_W = KEY_W + COUNT_BITS + IDX_W;
  localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(ENTRIES);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_DECIDE = 3'd2;
  localparam logic [2:0] S_UPDATE = 3'd3;
  localparam logic [2:0] S_DONE   = 3'd4;

  // Control state
  logic [2:0]         state, state_next;
  logic [CNT_W-1:0]   cnt, cnt_next;
  logic               pend, pend_next;
  logic [CAP_W-1:0]   capacity;
  logic [ENTRIES-1:0] entry_valid, entry_valid_next;
  logic [CNT_W-1:0]   resident, resident_next;
  logic               res_valid_next;

  // Request payload and decision
  logic [IDX_W-1:0]      pend_idx, pend_idx_next;
  logic [KEY_W-1:0]      key_q, key_q_next;
  logic [CMP_W-1:0]      cap_q, cap_q_next;
  logic [IDX_W-1:0]      target, target_next;
  logic [IDX_W-1:0]      limit, limit_next;
  logic                  age_all, age_all_next;
  logic [KEY_W-1:0]      tgt_key, tgt_key_next;
  logic [COUNT_BITS-1:0] tgt_count, tgt_count_next;
  logic                  r_hit, r_hit_next;
  logic                  r_evicted, r_evicted_next;
  logic [KEY_W-1:0]      r_key, r_key_next;
  logic                  do_insert, do_insert_next;

  logic [CMP_W-1:0] cap_eff;
  logic             issue;
  logic             full;
  logic             load_res;
  logic             cfg_wr;

  // Entry RAM and row unit
  logic             ram_we;
  logic [IDX_W-1:0] ram_raddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [ROW_W-1:0] ram_rdata;

  row_ctl_t              ctl;
  scan_res_t             sres;
  logic [IDX_W-1:0]      hit_slot, hit_rank, vic_slot, vic_rank, free_slot;
  logic [COUNT_BITS-1:0] hit_count, vic_count;
  logic [KEY_W-1:0]      vic_key;
  logic                  upd_en;
  logic [KEY_W-1:0]      upd_key;
  logic [COUNT_BITS-1:0] upd_count;
  logic [IDX_W-1:0]      upd_rank;

  // ---------------------------------------------------------------------
  // Configuration port: one register, writes complete in the access phase.
  // ---------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    if (paddr[APB_ADDR_W-1] == REG_CAPACITY) begin
      prdata = {{(APB_DATA_W - CAP_W){1'b0}}, capacity};
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr && (paddr[APB_ADDR_W-1] == REG_CAPACITY)) begin
      capacity <= pwdata[CAP_W-1:0];
    end
  end

  // Clamp the capacity to the table size.
  assign cap_eff = (CMP_W'(capacity) > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : CMP_W'(capacity);

  assign req_ready = (state == S_IDLE);

  // ---------------------------------------------------------------------
  // Entry RAM: one row is {key, use count, recency rank}.
  // ---------------------------------------------------------------------
  assign ram_wdata = {upd_key, upd_count, upd_rank};

  lfu_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pend_idx),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared compare unit: finds hit/victim/free in the first pass, ages
  // ranks and builds the written row in the second.
  lfu_row_unit #(
    .IDX_W      (IDX_W),
    .COUNT_BITS (COUNT_BITS)
  ) u_row (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .idx       (pend_idx),
    .row_key   (ram_rdata[ROW_W-1 -: KEY_W]),
    .row_count (ram_rdata[IDX_W +: COUNT_BITS]),
    .row_rank  (ram_rdata[IDX_W-1:0]),
    .req_key   (key_q),
    .target    (target),
    .limit     (limit),
    .age_all   (age_all),
    .tgt_key   (tgt_key),
    .tgt_count (tgt_count),
    .sres      (sres),
    .hit_slot  (hit_slot),
    .hit_rank  (hit_rank),
    .hit_count (hit_count),
    .vic_slot  (vic_slot),
    .vic_key   (vic_key),
    .vic_count (vic_count),
    .vic_rank  (vic_rank),
    .free_slot (free_slot),
    .upd_en    (upd_en),
    .upd_key   (upd_key),
    .upd_count (upd_count),
    .upd_rank  (upd_rank)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_next       = state;
    cnt_next         = cnt;
    pend_next        = 1'b0;
    pend_idx_next    = pend_idx;
    key_q_next       = key_q;
    cap_q_next       = cap_q;
    target_next      = target;
    limit_next       = limit;
    age_all_next     = age_all;
    tgt_key_next     = tgt_key;
    tgt_count_next   = tgt_count;
    r_hit_next       = r_hit;
    r_evicted_next   = r_evicted;
    r_key_next       = r_key;
    do_insert_next   = do_insert;
    entry_valid_next = entry_valid;
    resident_next    = resident;
    res_valid_next   = res_valid && !res_ready;
    load_res         = 1'b0;
    ram_we           = 1'b0;
    issue            = (cnt != LAST_CNT);
    ram_raddr        = cnt[IDX_W-1:0];
    full             = (CMP_W'(resident) >= cap_q);
    ctl              = '0;
    ctl.row_valid    = entry_valid[pend_idx];

    unique case (state)
      S_IDLE: begin
        if (req_valid) begin
          key_q_next = req_key;
          cap_q_next = cap_eff;
          cnt_next   = '0;
          ctl.clear  = 1'b1;
          if (cap_eff == '0) begin
            // Storing disabled: answer as a plain miss.
            r_hit_next     = 1'b0;
            r_evicted_next = 1'b0;
            r_key_next     = '0;
            do_insert_next = 1'b0;
            state_next     = S_DONE;
          end else begin
            state_next = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // Issue one read a cycle; evaluate the row read the cycle before.
        pend_next     = issue;
        pend_idx_next = cnt[IDX_W-1:0];
        if (issue) begin
          cnt_next = cnt + CNT_W'(1);
        end
        ctl.scan = pend;
        if (!issue && pend) begin
          state_next = S_DECIDE;
        end
      end

      S_DECIDE: begin
        cnt_next       = '0;
        tgt_key_next   = key_q;
        tgt_count_next = COUNT_BITS'(1);
        age_all_next   = 1'b0;
        r_hit_next     = 1'b0;
        r_evicted_next = 1'b0;
        r_key_next     = '0;
        do_insert_next = 1'b0;
        state_next     = S_UPDATE;
        if (sres.found) begin
          // Hit: bump the count, saturating, and make it most recent.
          target_next = hit_slot;
          limit_next  = hit_rank;
          r_hit_next  = 1'b1;
          if (hit_count != {COUNT_BITS{1'b1}}) begin
            tgt_count_next = hit_count + COUNT_BITS'(1);
          end else begin
            tgt_count_next = hit_count;
          end
        end else if (full && sres.have_victim) begin
          // Replace the least used, oldest entry in place.
          target_next    = vic_slot;
          limit_next     = vic_rank;
          r_evicted_next = 1'b1;
          r_key_next     = vic_key;
        end else if (sres.have_free) begin
          // Fill the lowest free slot; every resident entry ages.
          target_next    = free_slot;
          age_all_next   = 1'b1;
          do_insert_next = 1'b1;
        end else begin
          state_next = S_DONE;
        end
      end

      S_UPDATE: begin
        pend_next     = issue;
        pend_idx_next = cnt[IDX_W-1:0];
        if (issue) begin
          cnt_next = cnt + CNT_W'(1);
        end
        ctl.update = pend;
        ram_we     = pend && upd_en;
        if (!issue && pend) begin
          state_next = S_DONE;
        end
      end

      S_DONE: begin
        // Hold until the output register is free.
        if (!res_valid || res_ready) begin
          load_res       = 1'b1;
          res_valid_next = 1'b1;
          state_next     = S_IDLE;
          if (do_insert) begin
            entry_valid_next[target] = 1'b1;
            resident_next            = resident + CNT_W'(1);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      cnt         <= '0;
      pend        <= 1'b0;
      entry_valid <= '0;
      resident    <= '0;
      res_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      cnt         <= cnt_next;
      pend        <= pend_next;
      entry_valid <= entry_valid_next;
      resident    <= resident_next;
      res_valid   <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx  <= pend_idx_next;
    key_q     <= key_q_next;
    cap_q     <= cap_q_next;
    target    <= target_next;
    limit     <= limit_next;
    age_all   <= age_all_next;
    tgt_key   <= tgt_key_next;
    tgt_count <= tgt_count_next;
    r_hit     <= r_hit_next;
    r_evicted <= r_evicted_next;
    r_key     <= r_key_next;
    do_insert <= do_insert_next;
    if (load_res) begin
      hit         <= r_hit;
      evicted     <= r_evicted;
      evicted_key <= r_key;
    end
  end

  // ---------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------
  `LFU_ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && req_ready, !req_ready)
  `LFU_ASSERT_NOW(a_resident_bound, clk, rst, 1'b1, resident <= LAST_CNT)
  `LFU_ASSERT_NOW(a_hit_excludes_evict, clk, rst, res_valid, !(hit && evicted))
  `LFU_ASSERT_NOW(a_ram_write_in_update, clk, rst, ram_we, state == S_UPDATE)

endmodule
